### src/ipd_pkg.sv
// Package for the interval phase detector: sizes, types and helpers.
// Used by ipd_cell and interval_phase_detector; depends on nothing.
`default_nettype none
package ipd_pkg;
  localparam int MaxPhases = 16;
  localparam int CntW = 48;
  localparam int PhW = $clog2(MaxPhases);
  localparam int PcW = $clog2(MaxPhases + 1);

  typedef logic [31:0] sig_t [4];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  // a cell's compare result, carried between neighbors
  typedef struct packed {
    logic       hit;
    logic [PhW-1:0] idx;
  } scan_t;

  localparam logic [1:0] RegThresh = 2'd0;
  localparam logic [1:0] RegStable = 2'd1;

  function automatic logic [31:0] sat32(input logic [32:0] v);
    sat32 = v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] clip32(input logic [CntW-1:0] v);
    clip32 = (|v[CntW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] absd(input logic [31:0] a, input logic [31:0] b);
    absd = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic match(input logic [127:0] r, input logic [127:0] s,
                                 input logic [31:0] th);
    logic [33:0] d;
    d = 34'(absd(r[31:0], s[31:0])) + 34'(absd(r[63:32], s[63:32]))
      + 34'(absd(r[95:64], s[95:64])) + 34'(absd(r[127:96], s[127:96]));
    match = d <= 34'(th);
  endfunction
endpackage
`default_nettype wire

### src/ipd_cell.sv
// One signature table cell: holds one phase signature and checks it
// against the signature that passes along the chain. Depends on ipd_pkg.
`default_nettype none
module ipd_cell import ipd_pkg::*; (
  input  wire logic clk,
  input  wire logic [PhW-1:0] my_idx,
  input  wire logic [127:0] sig_in,     // signature travelling down the chain
  input  wire logic [127:0] wdata,      // value stored on a write
  input  wire logic [31:0]  thresh,
  input  wire logic         live,       // entry is below the phase count
  input  wire logic         wr,
  input  wire scan_t        scan_in,    // first hit from earlier cells
  output scan_t             scan_out,
  output logic [127:0]      entry
);
  logic [127:0] store;
  logic m;

  always_ff @(posedge clk) begin
    if (wr) begin
      store <= wdata;
    end
  end

  // first match wins: pass an earlier hit through unchanged
  always_comb begin
    m = live && match(store, sig_in, thresh);
    scan_out = scan_in;
    if (!scan_in.hit && m) begin
      scan_out.hit = 1'b1;
      scan_out.idx = my_idx;
    end
  end

  assign entry = store;
endmodule
`default_nettype wire

### src/interval_phase_detector.sv
// Interval phase detector top level: counter differencing, stability
// control and the chain of table cells. Depends on ipd_pkg and ipd_cell.
// Each input transfer is followed by a scan state and then an output
// state that offers the result until it is taken.
// The input is held off during the scan and while the result waits; a new
// item is taken at the edge where the result leaves.
// Reset (rst, synchronous): totals, candidate, counts cleared; registers
// return to threshold 10000, stable_intervals 4. Table contents undefined.
`default_nettype none
module interval_phase_detector import ipd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // alu, mult, branch, load, store, fp_alu, fp_mult totals (48 each)
  input  wire logic [335:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // int, branch, fp, mem counts (32 each), phase_valid, current_phase(4),
  // phase_count(5), pending_count(8), table_full, 5 bits zero pad
  output logic [151:0] m_tdata,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [31:0] thresh;
  logic [7:0]  stable;
  logic [CntW-1:0] prev [7];
  logic [127:0] sig, cand;
  logic cand_loaded;
  logic [PcW-1:0] nph;
  logic [PhW-1:0] act;
  logic [7:0] cnt;
  logic full;
  state_t state, state_next;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= 32'd10000;
      stable <= 8'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegStable[0]) stable <= pwdata[7:0];
      else thresh <= pwdata;
    end
  end
  always_comb begin
    prdata = (paddr[2] == RegStable[0]) ? {24'd0, stable} : thresh;
  end

  // first phase stores the candidate, every later write the new signature
  logic [127:0] wdata;
  assign wdata = (nph == '0) ? cand : sig;

  // cell chain
  scan_t chain [MaxPhases+1];
  logic [127:0] ent [MaxPhases];
  logic [MaxPhases-1:0] wr;
  assign chain[0] = '0;
  for (genvar g = 0; g < MaxPhases; g++) begin : g_cell
    ipd_cell u_cell (
      .clk(clk), .my_idx(PhW'(g)), .sig_in(sig), .wdata(wdata), .thresh(thresh),
      .live(PcW'(g) < nph), .wr(wr[g]), .scan_in(chain[g]),
      .scan_out(chain[g+1]), .entry(ent[g]));
  end

  logic [127:0] act_ent;
  assign act_ent = ent[act];

  // scan-step decisions
  logic [7:0] bump;
  logic cnf;
  assign bump = (cnt == 8'hFF) ? cnt : cnt + 8'd1;
  assign cnf = bump >= stable;

  logic        do_scan;
  assign s_tready = (state == ST_IDLE) || (state == ST_OUT && m_tready);
  assign do_scan = (state == ST_SCAN);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = s_tvalid ? ST_SCAN : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // table write enables
  always_comb begin
    wr = '0;
    if (do_scan) begin
      if (nph == '0) begin
        if (cand_loaded && match(cand, sig, thresh) && cnf) wr[0] = 1'b1;
      end else if (!match(act_ent, sig, thresh) && cnf) begin
        if (chain[MaxPhases].hit) wr[chain[MaxPhases].idx] = 1'b1;
        else if (nph < PcW'(MaxPhases)) wr[nph[PhW-1:0]] = 1'b1;
      end
    end
  end

  // differencing on transfer, state update in scan
  logic [CntW-1:0] cur [7];
  logic [31:0] d [7];
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      cur[i] = s_tdata[i*CntW +: CntW];
      d[i] = clip32(cur[i] - prev[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) prev[i] <= '0;
      cand <= '0; cand_loaded <= 1'b0; nph <= '0; act <= '0; cnt <= '0;
      full <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        for (int i = 0; i < 7; i++) prev[i] <= cur[i];
        sig <= {sat32({1'b0, d[3]} + {1'b0, d[4]}),
                sat32({1'b0, d[5]} + {1'b0, d[6]}), d[2],
                sat32({1'b0, d[0]} + {1'b0, d[1]})};
      end
      if (do_scan) begin
        full <= 1'b0;
        if (nph == '0) begin
          if (!cand_loaded) begin
            cand <= sig; cand_loaded <= 1'b1;
          end else if (!match(cand, sig, thresh)) begin
            cnt <= '0; cand <= sig;
          end else if (cnf) begin
            cnt <= '0; nph <= PcW'(1); act <= '0;
          end else cnt <= bump;
        end else if (match(act_ent, sig, thresh)) begin
          cnt <= '0;
        end else if (cnf) begin
          cnt <= '0;
          if (chain[MaxPhases].hit) act <= chain[MaxPhases].idx;
          else if (nph < PcW'(MaxPhases)) begin
            act <= nph[PhW-1:0]; nph <= nph + PcW'(1);
          end else full <= 1'b1;
        end else cnt <= bump;
      end
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {5'd0, full, cnt, nph, act, (nph != '0), sig};

  // assertions
  a_act: assert property (@(posedge clk) disable iff (rst)
    nph != '0 |-> PcW'(act) < nph) else $error("active phase out of range");
  a_nph: assert property (@(posedge clk) disable iff (rst)
    nph <= PcW'(MaxPhases)) else $error("phase count overflow");
  a_wr: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr)) else $error("multiple table writes");
endmodule
`default_nettype wire
